[hw/rtl/bdeq_pkg.sv]
// Shared constants, mode codes, controller states and command type for the deque.
package bdeq_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;

	localparam int          CAP_W     = 5;
	localparam logic [4:0]  CAP_RESET = 5'd16;

	localparam int          MODE_W        = 3;
	localparam logic [2:0]  MODE_REPORT   = 3'd0;
	localparam logic [2:0]  MODE_INS_FRONT = 3'd1;
	localparam logic [2:0]  MODE_INS_REAR  = 3'd2;
	localparam logic [2:0]  MODE_REM_FRONT = 3'd3;
	localparam logic [2:0]  MODE_REM_REAR  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic exec;
		logic rd;
		logic load;
	} ctrl_cmd_t;

endpackage

[hw/rtl/bdeq_in_if.sv]
// Request channel: operation mode and the word to insert.
interface bdeq_in_if
	import bdeq_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [MODE_W-1:0]           mode;
	logic signed [WORD_BITS-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);
endinterface

[hw/rtl/bdeq_out_if.sv]
// Response channel: outcome and the queue's state after the operation.
interface bdeq_out_if
	import bdeq_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int CNT_W     = $clog2(DEPTH_DEF + 1)
);
	logic                        valid;
	logic                        ready;
	logic                        ok;
	logic signed [WORD_BITS-1:0] front_word;
	logic signed [WORD_BITS-1:0] rear_word;
	logic                        is_empty;
	logic                        is_full;
	logic [CNT_W-1:0]            count;

	modport source (output valid, output ok, output front_word, output rear_word,
		output is_empty, output is_full, output count, input ready);
	modport sink   (input valid, input ok, input front_word, input rear_word,
		input is_empty, input is_full, input count, output ready);
endinterface

[hw/rtl/bounded_double_ended_queue.sv]
// Top level of the bounded double-ended queue: controller plus datapath.
//
// Usage: each transaction on req carries a mode (report, insert front,
// insert rear, remove front, remove rear) and a word; each one yields
// exactly one transaction on rsp with the outcome, the front and rear
// words (all ones when empty), the empty and full flags and the count.
// Insert into a full queue or removal from an empty one fails and
// leaves the queue unchanged; unknown modes report failure.
// cfg_we/cfg_wdata set the capacity, clamped to DEPTH; write it only
// while no request is in flight.
// Each request passes the execute, read and load steps in that order, with
// the registered two-port read of the store following the execute step;
// no new request is taken until the last one has been loaded.
// Reset empties the queue and sets the capacity to 16; the store is not
// cleared, since words read from an empty queue are masked to all ones.
// If the receiver stalls, the response waits in its output register;
// one further request is taken and waits in its load step until the
// register is free.
module bounded_double_ended_queue
	import bdeq_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	bdeq_in_if.sink          req,
	bdeq_out_if.source       rsp,
	input logic              cfg_we,
	input logic [CAP_W-1:0]  cfg_wdata
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	ctrl_cmd_t cmd;

	bdeq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	bdeq_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS),
		.CNT_W     (CNT_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (req.mode),
		.value      (req.value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.ok         (rsp.ok),
		.front_word (rsp.front_word),
		.rear_word  (rsp.rear_word),
		.is_empty   (rsp.is_empty),
		.is_full    (rsp.is_full),
		.count      (rsp.count)
	);

endmodule

[hw/rtl/bdeq_ctrl.sv]
// Controller state machine: sequences execute, memory read and response load.
module bdeq_ctrl
	import bdeq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.exec = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				// The response register is reused only once its transaction is gone.
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!rsp_valid_q || rsp_ready))
		else $error("response register overwritten while still pending");

	a_exec_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (state_q == ST_READ && !req_ready))
		else $error("executed request not followed by the read step");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.exec, cmd.rd, cmd.load}))
		else $error("more than one datapath command in a cycle");

endmodule

[hw/rtl/bdeq_dp.sv]
// Datapath: ring store, head index, held count, capacity and response registers.
module bdeq_dp
	import bdeq_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ctrl_cmd_t                   cmd,
	input  logic [MODE_W-1:0]           mode,
	input  logic signed [WORD_BITS-1:0] value,
	input  logic                        cfg_we,
	input  logic [CAP_W-1:0]            cfg_wdata,
	output logic                        ok,
	output logic signed [WORD_BITS-1:0] front_word,
	output logic signed [WORD_BITS-1:0] rear_word,
	output logic                        is_empty,
	output logic                        is_full,
	output logic [CNT_W-1:0]            count
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int SUM_W = CNT_W + 1;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

	logic [WORD_BITS-1:0] mem [DEPTH];

	logic [IDX_W-1:0]     head_q;
	logic [CNT_W-1:0]     count_q;
	logic [CAP_W-1:0]     cap_q;
	logic                 ok_q;
	logic [WORD_BITS-1:0] rd_front_q;
	logic [WORD_BITS-1:0] rd_rear_q;

	logic                 rsp_ok_q;
	logic [WORD_BITS-1:0] rsp_front_q;
	logic [WORD_BITS-1:0] rsp_rear_q;
	logic                 rsp_empty_q;
	logic                 rsp_full_q;
	logic [CNT_W-1:0]     rsp_count_q;

	logic [CMP_W-1:0]     eff_cap;
	logic                 full;
	logic                 empty;
	logic [IDX_W-1:0]     head_dec;
	logic [IDX_W-1:0]     head_inc;
	logic [SUM_W-1:0]     ins_sum;
	logic [SUM_W-1:0]     ins_wrap;
	logic [SUM_W-1:0]     rear_sum;
	logic [SUM_W-1:0]     rear_wrap;
	logic [IDX_W-1:0]     ins_addr;
	logic [IDX_W-1:0]     rear_addr;

	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [IDX_W-1:0]     head_d;
	logic [CNT_W-1:0]     count_d;
	logic                 ok_d;

	assign eff_cap = (CMP_W'(cap_q) > DEPTH_C) ? DEPTH_C : CMP_W'(cap_q);
	assign full    = CMP_W'(count_q) >= eff_cap;
	assign empty   = (count_q == '0);

	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;

	// Wherever a sum is used it stays below twice the depth, so one conditional
	// subtract wraps it; the rear sum of an empty queue is masked at the output.
	assign ins_sum   = SUM_W'(head_q) + SUM_W'(count_q);
	assign ins_wrap  = (ins_sum >= DEPTH_S) ? ins_sum - DEPTH_S : ins_sum;
	assign ins_addr  = ins_wrap[IDX_W-1:0];
	assign rear_sum  = SUM_W'(head_q) + SUM_W'(count_q - 1'b1);
	assign rear_wrap = (rear_sum >= DEPTH_S) ? rear_sum - DEPTH_S : rear_sum;
	assign rear_addr = rear_wrap[IDX_W-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = head_q;
		head_d    = head_q;
		count_d   = count_q;
		ok_d      = 1'b0;
		case (mode)
			MODE_REPORT: begin
				ok_d = 1'b1;
			end
			MODE_INS_FRONT: begin
				if (!full) begin
					mem_we    = 1'b1;
					mem_waddr = head_dec;
					head_d    = head_dec;
					count_d   = count_q + 1'b1;
					ok_d      = 1'b1;
				end
			end
			MODE_INS_REAR: begin
				if (!full) begin
					mem_we    = 1'b1;
					mem_waddr = ins_addr;
					count_d   = count_q + 1'b1;
					ok_d      = 1'b1;
				end
			end
			MODE_REM_FRONT: begin
				if (!empty) begin
					head_d  = head_inc;
					count_d = count_q - 1'b1;
					ok_d    = 1'b1;
				end
			end
			MODE_REM_REAR: begin
				if (!empty) begin
					count_d = count_q - 1'b1;
					ok_d    = 1'b1;
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && mem_we) begin
			mem[mem_waddr] <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			ok_q <= ok_d;
		end
		if (cmd.rd) begin
			rd_front_q <= mem[head_q];
			rd_rear_q  <= mem[rear_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_ok_q    <= ok_q;
			rsp_front_q <= empty ? '1 : rd_front_q;
			rsp_rear_q  <= empty ? '1 : rd_rear_q;
			rsp_empty_q <= empty;
			rsp_full_q  <= full;
			rsp_count_q <= count_q;
		end
	end

	assign ok         = rsp_ok_q;
	assign front_word = rsp_front_q;
	assign rear_word  = rsp_rear_q;
	assign is_empty   = rsp_empty_q;
	assign is_full    = rsp_full_q;
	assign count      = rsp_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= DEPTH_C)
		else $error("held count exceeds the store depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(head_q) < DEPTH_S)
		else $error("head index outside the store");

endmodule
